[rtl/core/pror_pkg.sv]
// Shared types and constants for the PC range owner resolver.
package pror_pkg;

  localparam int ADDR_W = 64;
  localparam int VER_W = 32;
  localparam int IDX_W = 6;
  localparam int GRP_W = 6;
  localparam int CNT_W = 7;
  localparam int MAX_SLOTS = 2 ** IDX_W;
  localparam int TABLE_ENTRIES_DEF = 64;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [IDX_W-1:0]  entry_index;
    logic [ADDR_W-1:0] entry_start;
    logic [ADDR_W-1:0] entry_length;
    logic [VER_W-1:0]  entry_version;
    logic [GRP_W-1:0]  entry_group;
    logic [ADDR_W-1:0] lookup_pc;
  } in_item_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] owner_index;
    logic [VER_W-1:0] owner_version;
    logic [GRP_W-1:0] owner_group;
  } out_item_t;

  typedef struct packed {
    logic             own;
    logic [IDX_W-1:0] idx;
    logic [VER_W-1:0] ver;
    logic [GRP_W-1:0] grp;
  } cand_t;

endpackage

[rtl/core/pror_table.sv]
// Region table registers with the parallel range match stage.
module pror_table #(
  parameter int SLOTS = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  pror_pkg::in_item_t         in_item,
  input  logic [pror_pkg::CNT_W-1:0] count,
  output logic                       leaf_valid,
  output pror_pkg::cand_t            leaves [SLOTS]
);
  import pror_pkg::*;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W:0] SLOT_LIMIT = (IDX_W + 1)'(SLOTS);

  logic [ADDR_W-1:0] region_start [SLOTS];
  logic [ADDR_W-1:0] region_end [SLOTS];
  logic [SLOTS-1:0]  region_wrap;
  logic [SLOTS-1:0]  region_zero;
  logic [VER_W-1:0]  region_ver [SLOTS];
  logic [GRP_W-1:0]  region_grp [SLOTS];

  logic [ADDR_W:0]   end_sum;
  logic              wr_fire;
  logic [SLOT_W-1:0] wr_slot;
  logic              is_lookup;
  logic [SLOTS-1:0]  own_next;

  logic [SLOTS-1:0]  leaf_own;
  logic [VER_W-1:0]  leaf_ver [SLOTS];
  logic [GRP_W-1:0]  leaf_grp [SLOTS];

  assign end_sum = {1'b0, in_item.entry_start} + {1'b0, in_item.entry_length};
  assign wr_slot = in_item.entry_index[SLOT_W-1:0];
  assign is_lookup = (in_item.operation == OP_LOOKUP);
  assign wr_fire = in_valid && en && (in_item.operation == OP_WRITE) &&
                   ({1'b0, in_item.entry_index} < SLOT_LIMIT);

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      region_start[wr_slot] <= in_item.entry_start;
      region_end[wr_slot]   <= end_sum[ADDR_W-1:0];
      region_wrap[wr_slot]  <= end_sum[ADDR_W];
      region_zero[wr_slot]  <= (in_item.entry_length == '0);
      region_ver[wr_slot]   <= in_item.entry_version;
      region_grp[wr_slot]   <= in_item.entry_group;
    end
  end

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      logic covers;
      if (region_zero[i]) begin
        covers = (in_item.lookup_pc == region_start[i]);
      end else if (region_wrap[i]) begin
        covers = (in_item.lookup_pc >= region_start[i]);
      end else begin
        covers = (in_item.lookup_pc >= region_start[i]) &&
                 (in_item.lookup_pc < region_end[i]);
      end
      own_next[i] = is_lookup && (CNT_W'(i) < count) && covers;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      leaf_valid <= 1'b0;
    end else if (en) begin
      leaf_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      leaf_own <= own_next;
      for (int i = 0; i < SLOTS; i++) begin
        leaf_ver[i] <= region_ver[i];
        leaf_grp[i] <= region_grp[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      leaves[i].own = leaf_own[i];
      leaves[i].idx = IDX_W'(i);
      leaves[i].ver = leaf_ver[i];
      leaves[i].grp = leaf_grp[i];
    end
  end

`ifndef SYNTHESIS
  a_write_lands: assert property (@(posedge clk) disable iff (rst)
    wr_fire |=> region_ver[$past(wr_slot)] == $past(in_item.entry_version))
    else $error("table write did not land in its slot");

  a_write_no_owner: assert property (@(posedge clk) disable iff (rst)
    (en && in_valid && in_item.operation == OP_WRITE) |=> (leaf_valid && leaf_own == '0))
    else $error("write item produced a region owner");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> ($stable(leaf_valid) && $stable(leaf_own)))
    else $error("match stage changed while stalled");
`endif

endmodule

[rtl/core/pror_tree.sv]
// Pipelined winner selection tree, one register level per tree level.
module pror_tree #(
  parameter int SLOTS = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            valid_in,
  input  pror_pkg::cand_t leaves [SLOTS],
  output logic            valid_out,
  output pror_pkg::cand_t best
);
  import pror_pkg::*;

  localparam int LVL = $clog2(SLOTS);
  localparam int LEAVES = 1 << LVL;

  function automatic cand_t pick(cand_t lo, cand_t hi);
    cand_t res;
    res = (hi.own && (!lo.own || hi.ver >= lo.ver)) ? hi : lo;
    return res;
  endfunction

  generate
    if (LVL == 0) begin : g_flat
      assign valid_out = valid_in;
      assign best = leaves[0];
    end else begin : g_tree
      cand_t         all_c [2*LEAVES-1];
      cand_t         nodes [LEAVES-1];
      logic [LVL-1:0] vld;

      for (genvar k = 0; k < LEAVES; k++) begin : g_leaf
        if (k < SLOTS) begin : g_used
          assign all_c[k] = leaves[k];
        end else begin : g_pad
          assign all_c[k] = '0;
        end
      end

      for (genvar j = 0; j < LEAVES - 1; j++) begin : g_node
        assign all_c[LEAVES+j] = nodes[j];
      end

      always_ff @(posedge clk) begin
        if (en) begin
          for (int j = 0; j < LEAVES - 1; j++) begin
            nodes[j] <= pick(all_c[2*j], all_c[2*j+1]);
          end
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          vld <= '0;
        end else if (en) begin
          vld[0] <= valid_in;
          for (int l = 1; l < LVL; l++) begin
            vld[l] <= vld[l-1];
          end
        end
      end

      assign valid_out = vld[LVL-1];
      assign best = nodes[LEAVES-2];
    end
  endgenerate

endmodule

[rtl/core/pc_range_owner_resolver_core.sv]
// Top level of the PC range owner resolver: handshake, register and output stage.
//
// Input items arrive on in_valid/in_stall with in_item. A write item loads one
// table slot and returns a result with every field zero. A lookup item returns
// the owning region with the greatest version, ties going to the higher index,
// or all zeros on a miss. Every item yields exactly one result on out_valid/out_stall.
// The entries_in_use register is written through cfg_valid/cfg_ready; write it only
// while the block is idle, which it does not enforce itself; cfg_ready is always high.
// From acceptance to out_valid an item passes one range match stage, one register
// level per winner tree level, and the output register. One item is accepted every
// cycle while the output is not stalled.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is dropped or repeated.
// Reset clears the pipeline valid bits and entries_in_use; table contents are
// undefined until written and are not cleared.
module pc_range_owner_resolver_core #(
  parameter int TABLE_ENTRIES = pror_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  pror_pkg::in_item_t         in_item,
  output logic                       out_valid,
  input  logic                       out_stall,
  output pror_pkg::out_item_t        out_item,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [pror_pkg::CNT_W-1:0] cfg_data
);
  import pror_pkg::*;

  localparam int SLOTS = (TABLE_ENTRIES < MAX_SLOTS) ? TABLE_ENTRIES : MAX_SLOTS;
  localparam logic [IDX_W:0] SLOT_LIMIT = (IDX_W + 1)'(SLOTS);

  logic             en;
  logic [CNT_W-1:0] entries_in_use;
  logic             leaf_valid;
  cand_t            leaves [SLOTS];
  logic             tree_valid;
  cand_t            best;

  assign en = !(out_valid && out_stall);
  assign in_stall = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= '0;
    end else if (cfg_valid) begin
      entries_in_use <= cfg_data;
    end
  end

  pror_table #(
    .SLOTS(SLOTS)
  ) u_table (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .count     (entries_in_use),
    .leaf_valid(leaf_valid),
    .leaves    (leaves)
  );

  pror_tree #(
    .SLOTS(SLOTS)
  ) u_tree (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .valid_in (leaf_valid),
    .leaves   (leaves),
    .valid_out(tree_valid),
    .best     (best)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= tree_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (best.own) begin
        out_item.hit           <= 1'b1;
        out_item.owner_index   <= best.idx;
        out_item.owner_version <= best.ver;
        out_item.owner_group   <= best.grp;
      end else begin
        out_item <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_hit_in_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.hit) |->
      (({1'b0, out_item.owner_index} < entries_in_use) &&
       ({1'b0, out_item.owner_index} < SLOT_LIMIT)))
    else $error("hit names a slot outside the active table");
`endif

endmodule
